### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the polygon transform block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/core/pat_pkg.sv
// Package for the polygon affine transform block: command codes, state
// types, CORDIC constants and the arctangent table. No dependencies.
package pat_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 32;

  localparam int CORDIC_STEPS    = 18;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int DEG_FULL        = 23592960;  // 360 degrees in Q16.16
  localparam int DEG_HALF        = 11796480;
  localparam int DEG_QUARTER     = 5898240;
  localparam int RED_TOP         = 6;         // highest shift of the modulo sweep

  typedef enum logic [2:0] {
    CMD_LOAD      = 3'd0,
    CMD_COPY      = 3'd1,
    CMD_SCALE     = 3'd2,
    CMD_TRANSLATE = 3'd3,
    CMD_ROTATE    = 3'd4,
    CMD_FLUSH     = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT, ST_COPY_RD, ST_COPY_WR,
    ST_TRIG, ST_XF_RD, ST_MUL_LO, ST_MUL_HI, ST_MUL_FIN, ST_XF_WR, ST_FIN
  } top_st_t;

  typedef enum logic [2:0] {
    SC_IDLE, SC_RED, SC_FOLD, SC_ITER, SC_DONE
  } sc_st_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] sin_q30;
    logic signed [31:0] cos_q30;
  } trig_t;

  // atan(2^-i) in degrees, Q16.16.
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/pat_ifs.sv
// Valid/ready channel interfaces for the polygon transform block.
// No dependencies.
interface pat_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic               last_vertex;
  modport source (output valid, command, value_a, value_b, last_vertex, input ready);
  modport sink   (input valid, command, value_a, value_b, last_vertex, output ready);
endinterface

interface pat_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

### rtl/core/pat_sincos.sv
// Sine and cosine of an angle in degrees: modulo-360 sweep then an
// 18-step CORDIC, one step per cycle. Depends on pat_pkg.
module pat_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output pat_pkg::trig_t     res
);
  import pat_pkg::*;

  localparam int XW = 34;
  localparam int ZW = 27;
  localparam logic signed [ZW-1:0] Z_FULL = ZW'(DEG_FULL);
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(DEG_HALF);
  localparam logic signed [ZW-1:0] Z_QTR  = ZW'(DEG_QUARTER);

  sc_st_t               st_r, st_nxt;
  logic [31:0]          rem_r;
  logic                 neg_r, flip_r;
  logic [4:0]           step_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  logic [31:0]          a_mag;
  logic [32:0]          dsh;
  logic                 ge;
  logic signed [ZW-1:0] z0, z1, z2, at;
  logic                 flip_nxt;
  logic signed [XW-1:0] dx, dy, nx, ny;

  always_comb begin
    a_mag = angle[31] ? 32'(-angle) : 32'(angle);
    dsh   = 33'(DEG_FULL) << step_r;
    ge    = {1'b0, rem_r} >= dsh;
    // C-style remainder takes the sign of the angle; bring it into [0, 360).
    z0 = (neg_r && rem_r != 32'd0) ? Z_FULL - signed'(ZW'(rem_r)) : signed'(ZW'(rem_r));
    z1 = (z0 >= Z_HALF) ? z0 - Z_FULL : z0;
    flip_nxt = 1'b0;
    z2 = z1;
    if (z1 > Z_QTR) begin
      z2 = z1 - Z_HALF;
      flip_nxt = 1'b1;
    end else if (z1 < -Z_QTR) begin
      z2 = z1 + Z_HALF;
      flip_nxt = 1'b1;
    end
    at = signed'(ZW'(atan_deg(step_r)));
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    nx = -x_r;
    ny = -y_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SC_IDLE: if (start) st_nxt = SC_RED;
      SC_RED:  if (step_r == 5'd0) st_nxt = SC_FOLD;
      SC_FOLD: st_nxt = SC_ITER;
      SC_ITER: if (step_r == 5'(CORDIC_STEPS - 1)) st_nxt = SC_DONE;
      SC_DONE: st_nxt = SC_IDLE;
      default: st_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SC_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      SC_IDLE: begin
        if (start) begin
          rem_r  <= a_mag;
          neg_r  <= angle[31];
          step_r <= 5'(RED_TOP);
        end
      end
      SC_RED: begin
        if (ge) rem_r <= rem_r - dsh[31:0];
        step_r <= step_r - 5'd1;
      end
      SC_FOLD: begin
        z_r    <= z2;
        flip_r <= flip_nxt;
        x_r    <= XW'(CORDIC_GAIN_Q30);
        y_r    <= '0;
        step_r <= '0;
      end
      SC_ITER: begin
        if (!z_r[ZW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        step_r <= step_r + 5'd1;
      end
      default: ;
    endcase
  end

  assign res.done    = (st_r == SC_DONE);
  assign res.sin_q30 = flip_r ? ny[31:0] : y_r[31:0];
  assign res.cos_q30 = flip_r ? nx[31:0] : x_r[31:0];

endmodule

### rtl/core/polygon_affine_transform_top.sv
// Top level of the polygon affine transform block: vertex stores,
// sequencer and shared multiplier. Depends on pat_pkg, pat_ifs, pat_sincos.
//
// Usage: commands arrive one word at a time on in_ch (valid/ready). A load
// word stores one vertex of the original polygon. All other commands make
// the block busy (in_ch.ready low) until done. Copy and flush emit the
// working polygon on out_ch, one word per vertex, with last_point on the
// final vertex; each vertex passes read, load and wait states, and a stalled
// receiver simply holds the block in place, the output word staying stable
// in its register. A copy then reloads the working store with a read and a
// write state per vertex. Translate handles each vertex with a read and a
// write-back state; scale puts two products, rotate four, on the one shared
// 32x32 multiplier between them (low half, high half and finish states each),
// rotate after a sine/cosine pass (7-step modulo sweep, a fold state, 18
// CORDIC steps and a done state). Every command other than a load ends with
// a bookkeeping state. Reset (rst_n low, synchronous) empties both polygons
// and clears the load position; vertex storage itself is not cleared.
`include "assert_macros.svh"
module polygon_affine_transform_top #(
  parameter int MAX_VERTICES = pat_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pat_pkg::COORD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pat_in_if.sink    in_ch,
  pat_out_if.source out_ch
);
  import pat_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int EW    = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
  localparam int ACC_W = COORD_WIDTH + 33;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [EW-1:0] EW_CMAX = EW'(CMAX);
  localparam logic signed [EW-1:0] EW_CMIN = EW'(CMIN);
  localparam logic signed [EW-1:0] O_MAX = EW'(32'sh7FFF_FFFF);
  localparam logic signed [EW-1:0] O_MIN = EW'(32'sh8000_0000);
  localparam logic [ACC_W-1:0] QMAX  = ACC_W'(CMAX);
  localparam logic [ACC_W-1:0] QMAXN = QMAX + ACC_W'(1);
  localparam logic [ACC_W-1:0] RND16 = ACC_W'(1) << 15;
  localparam logic [ACC_W-1:0] RND30 = ACC_W'(1) << 29;

  function automatic logic signed [COORD_WIDTH-1:0] sat_c(input logic signed [EW-1:0] v);
    if (v > EW_CMAX) return CMAX;
    else if (v < EW_CMIN) return CMIN;
    else return v[COORD_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] out32(input logic signed [COORD_WIDTH-1:0] x);
    logic signed [EW-1:0] v;
    v = EW'(x);
    if (v > O_MAX) return 32'h7FFF_FFFF;
    else if (v < O_MIN) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  // Sequencer and bookkeeping.
  top_st_t                 st_r, st_nxt;
  cmd_t                    cmd_r, in_cmd;
  logic signed [31:0]      a_r, b_r;
  logic [CNT_W-1:0]        idx_r, orig_count_r, work_count_r, load_pos_r, pos_adv;
  logic                    work_valid_r;
  logic [1:0]              pidx_r, pidx_last;
  logic [ACC_W-1:0]        acc_r;
  logic signed [COORD_WIDTH-1:0] p_r [4];

  // Output word register.
  logic                    out_valid_r, out_last_r;
  logic [31:0]             out_x_r, out_y_r;

  // Vertex stores.
  logic [COORD_WIDTH-1:0]  orig_x_mem [MAX_VERTICES];
  logic [COORD_WIDTH-1:0]  orig_y_mem [MAX_VERTICES];
  logic [COORD_WIDTH-1:0]  work_x_mem [MAX_VERTICES];
  logic [COORD_WIDTH-1:0]  work_y_mem [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] o_rd_x_r, o_rd_y_r, w_rd_x_r, w_rd_y_r;

  logic                    in_ready, in_fire, out_fire, emit_ok, w_last, o_last;
  logic                    orig_we, work_we, trig_start;
  logic signed [COORD_WIDTH-1:0] ld_x, ld_y, wr_x, wr_y, new_x, new_y;
  logic signed [COORD_WIDTH-1:0] v_sel, p_val;
  logic signed [31:0]      f_sel;
  logic [COORD_WIDTH-1:0]  mag_v;
  logic [31:0]             mag_f, mul_a;
  logic [63:0]             vext, prod;
  logic [ACC_W-1:0]        q, rnd;
  logic                    mneg, is_rot;
  trig_t                   trig;

  pat_sincos u_sincos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (in_ch.value_a),
    .res   (trig)
  );

  assign in_ready     = (st_r == ST_IDLE);
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign in_cmd       = cmd_t'(in_ch.command);
  assign emit_ok      = work_valid_r && (work_count_r != '0);
  assign w_last       = (idx_r + CNT_W'(1)) == work_count_r;
  assign o_last       = (idx_r + CNT_W'(1)) == orig_count_r;
  assign pos_adv      = (load_pos_r < CNT_W'(MAX_VERTICES)) ? load_pos_r + CNT_W'(1)
                                                            : load_pos_r;
  assign orig_we      = in_fire && (in_cmd == CMD_LOAD) &&
                        (load_pos_r < CNT_W'(MAX_VERTICES));
  assign trig_start   = in_fire && (in_cmd == CMD_ROTATE) && (work_count_r != '0);
  assign ld_x         = sat_c(EW'(in_ch.value_a));
  assign ld_y         = sat_c(EW'(in_ch.value_b));
  assign is_rot       = (cmd_r == CMD_ROTATE);
  assign pidx_last    = is_rot ? 2'd3 : 2'd1;

  // Shared multiplier. Rotation products run x*c, y*s, x*s, y*c; scale runs
  // x*a, y*b. Magnitudes are multiplied in two 32-bit halves of the vertex.
  always_comb begin
    v_sel = pidx_r[0] ? w_rd_y_r : w_rd_x_r;
    if (is_rot) begin
      f_sel = (pidx_r == 2'd1 || pidx_r == 2'd2) ? trig.sin_q30 : trig.cos_q30;
    end else begin
      f_sel = pidx_r[0] ? b_r : a_r;
    end
    mag_v = v_sel[COORD_WIDTH-1] ? COORD_WIDTH'(-v_sel) : COORD_WIDTH'(v_sel);
    mag_f = f_sel[31] ? 32'(-f_sel) : 32'(f_sel);
    vext  = 64'(mag_v);
    mul_a = (st_r == ST_MUL_HI) ? vext[63:32] : vext[31:0];
    prod  = mul_a * mag_f;
    rnd   = is_rot ? RND30 : RND16;
    q     = is_rot ? (acc_r >> 30) : (acc_r >> 16);
    mneg  = v_sel[COORD_WIDTH-1] ^ f_sel[31];
    if (mneg) begin
      p_val = (q > QMAXN) ? CMIN : COORD_WIDTH'(~q[COORD_WIDTH-1:0] + 1'b1);
    end else begin
      p_val = (q > QMAX) ? CMAX : q[COORD_WIDTH-1:0];
    end
  end

  // New vertex value for the write-back cycle.
  always_comb begin
    case (cmd_r)
      CMD_TRANSLATE: begin
        new_x = sat_c(EW'(w_rd_x_r) + EW'(a_r));
        new_y = sat_c(EW'(w_rd_y_r) + EW'(b_r));
      end
      CMD_SCALE: begin
        new_x = p_r[0];
        new_y = p_r[1];
      end
      default: begin
        new_x = sat_c(EW'(p_r[0]) - EW'(p_r[1]));
        new_y = sat_c(EW'(p_r[2]) + EW'(p_r[3]));
      end
    endcase
    work_we = (st_r == ST_COPY_WR) || (st_r == ST_XF_WR);
    wr_x    = (st_r == ST_COPY_WR) ? o_rd_x_r : new_x;
    wr_y    = (st_r == ST_COPY_WR) ? o_rd_y_r : new_y;
  end

  always_ff @(posedge clk) begin
    if (orig_we) begin
      orig_x_mem[load_pos_r[IDX_W-1:0]] <= ld_x;
      orig_y_mem[load_pos_r[IDX_W-1:0]] <= ld_y;
    end
    o_rd_x_r <= orig_x_mem[idx_r[IDX_W-1:0]];
    o_rd_y_r <= orig_y_mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_x_mem[idx_r[IDX_W-1:0]] <= wr_x;
      work_y_mem[idx_r[IDX_W-1:0]] <= wr_y;
    end
    w_rd_x_r <= work_x_mem[idx_r[IDX_W-1:0]];
    w_rd_y_r <= work_y_mem[idx_r[IDX_W-1:0]];
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd) inside
            CMD_LOAD:   st_nxt = ST_IDLE;
            CMD_COPY:   st_nxt = emit_ok ? ST_EMIT_RD :
                                 (orig_count_r != '0) ? ST_COPY_RD : ST_FIN;
            CMD_FLUSH:  st_nxt = emit_ok ? ST_EMIT_RD : ST_FIN;
            CMD_SCALE, CMD_TRANSLATE:
                        st_nxt = (work_count_r != '0) ? ST_XF_RD : ST_FIN;
            CMD_ROTATE: st_nxt = (work_count_r != '0) ? ST_TRIG : ST_FIN;
            default:    st_nxt = ST_FIN;
          endcase
        end
      end
      ST_EMIT_RD: st_nxt = ST_EMIT_LD;
      ST_EMIT_LD: st_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_fire) begin
          if (!w_last) st_nxt = ST_EMIT_RD;
          else if (cmd_r == CMD_COPY && orig_count_r != '0) st_nxt = ST_COPY_RD;
          else st_nxt = ST_FIN;
        end
      end
      ST_COPY_RD: st_nxt = ST_COPY_WR;
      ST_COPY_WR: st_nxt = o_last ? ST_FIN : ST_COPY_RD;
      ST_TRIG:    if (trig.done) st_nxt = ST_XF_RD;
      ST_XF_RD:   st_nxt = (cmd_r == CMD_TRANSLATE) ? ST_XF_WR : ST_MUL_LO;
      ST_MUL_LO:  st_nxt = ST_MUL_HI;
      ST_MUL_HI:  st_nxt = ST_MUL_FIN;
      ST_MUL_FIN: st_nxt = (pidx_r == pidx_last) ? ST_XF_WR : ST_MUL_LO;
      ST_XF_WR:   st_nxt = w_last ? ST_FIN : ST_XF_RD;
      ST_FIN:     st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      orig_count_r <= '0;
      work_count_r <= '0;
      load_pos_r   <= '0;
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_r <= in_cmd;
            a_r   <= in_ch.value_a;
            b_r   <= in_ch.value_b;
            idx_r <= '0;
            if (in_cmd == CMD_LOAD) begin
              // Past the store's depth vertices are dropped.
              if (in_ch.last_vertex) begin
                orig_count_r <= pos_adv;
                load_pos_r   <= '0;
              end else begin
                load_pos_r   <= pos_adv;
              end
            end
          end
        end
        ST_EMIT_LD: begin
          out_x_r     <= out32(w_rd_x_r);
          out_y_r     <= out32(w_rd_y_r);
          out_last_r  <= w_last;
          out_valid_r <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            idx_r       <= w_last ? '0 : idx_r + CNT_W'(1);
          end
        end
        ST_COPY_WR: idx_r  <= idx_r + CNT_W'(1);
        ST_XF_RD:   pidx_r <= '0;
        ST_MUL_LO:  acc_r  <= ACC_W'(prod) + rnd;
        ST_MUL_HI:  acc_r  <= acc_r + (ACC_W'(prod) << 32);
        ST_MUL_FIN: begin
          p_r[pidx_r] <= p_val;
          pidx_r      <= pidx_r + 2'd1;
        end
        ST_XF_WR:   idx_r  <= idx_r + CNT_W'(1);
        ST_FIN: begin
          if (cmd_r == CMD_COPY) begin
            work_count_r <= orig_count_r;
            work_valid_r <= 1'b1;
          end else if (cmd_r == CMD_FLUSH) begin
            work_count_r <= '0;
            work_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.point_x    = out_x_r;
  assign out_ch.point_y    = out_y_r;
  assign out_ch.last_point = out_last_r;

  // The block never takes a command while an output word is pending.
  `ASSERT_NEVER(a_ready_vs_out, clk, rst_n, in_ch.ready && out_ch.valid, "ready while word pending")
  // The working count never exceeds the store depth.
  `ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, work_count_r <= CNT_W'(MAX_VERTICES), "count range")
  // The last flag marks exactly the final stored vertex.
  `ASSERT_IMPLY(a_last_idx, clk, rst_n, out_ch.valid && out_ch.last_point, w_last, "last flag misplaced")
  // Sine and cosine finish only while the sequencer waits for them.
  `ASSERT_IMPLY(a_trig_done, clk, rst_n, trig.done, st_r == ST_TRIG, "unexpected trig done")

endmodule

### bench/tb_polygon_affine_transform_top.sv
// Self-checking bench for polygon_affine_transform_top: drives command words,
// predicts every emitted vertex and checks the output stream word by word.
// Depends on pat_pkg, pat_ifs and the block RTL.
`timescale 1ns / 100ps
module tb_polygon_affine_transform_top;
  import pat_pkg::*;

  localparam int    NVERT      = 64;
  localparam longint CMAX      = 64'sd2147483647;
  localparam longint CMIN      = -64'sd2147483648;
  localparam int    WDOG_LIMIT = 20000;
  localparam int    TAIL_WAIT  = 1500;  // longer than one full rotate pass
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  command;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic        last_vertex;
    bit          drain_first;  // hold this word back until all points are out
  } cmd_word_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  pat_in_if  in_ch();
  pat_out_if out_ch();

  polygon_affine_transform_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, and the vertices we expect the block to emit.
  cmd_word_t cmd_queue[$];
  point_t    point_queue[$];
  int        error_count = 0;
  int        words_sent = 0;
  int        points_seen = 0;
  int        idle_cycles = 0;
  bit        quiet_stretch = 0;

  // Shadow copy of the block's polygon state.
  longint orig_x[NVERT], orig_y[NVERT], work_x[NVERT], work_y[NVERT];
  int     orig_cnt = 0, work_cnt = 0, load_pos = 0;
  bit     work_valid = 0;

  // Arctangent of 2^-i in degrees, Q16.16.
  const longint atan_q16[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115, 57, 29};

  function automatic longint clamp32(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // Sign-magnitude multiply with round half away from zero, then saturate.
  function automatic longint fix_mul(longint v, longint f, int sh);
    bit neg;
    longint unsigned mv, mf, m;
    neg = (v < 0) != (f < 0);
    mv = (v < 0) ? -v : v;
    mf = (f < 0) ? -f : f;
    m = (mv * mf + (64'd1 << (sh - 1))) >> sh;
    if (neg) return (m > 64'd2147483648) ? CMIN : -longint'(m);
    return (m > 64'd2147483647) ? CMAX : longint'(m);
  endfunction

  // Angle in Q16.16 degrees to sine and cosine in Q2.30 by rotation CORDIC.
  task automatic angle_sincos(input longint ang, output longint s, output longint c);
    longint z, x, y, dx, dy, full, half, quarter;
    bit flip;
    full = DEG_FULL; half = DEG_HALF; quarter = DEG_QUARTER;
    z = ang % full;
    x = CORDIC_GAIN_Q30;
    y = 0;
    flip = 0;
    if (z < 0) z += full;
    if (z >= half) z -= full;
    if (z > quarter) begin
      z -= half; flip = 1;
    end else if (z < -quarter) begin
      z += half; flip = 1;
    end
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q16[i];
      end else begin
        x += dx; y -= dy; z += atan_q16[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic emit_working();
    point_t p;
    if (!work_valid) return;
    for (int k = 0; k < work_cnt; k++) begin
      p.x = work_x[k][31:0];
      p.y = work_y[k][31:0];
      p.last = (k + 1 == work_cnt);
      point_queue.push_back(p);
    end
  endtask

  // Apply one accepted word to the shadow state and queue what it emits.
  task automatic apply_command(input logic [2:0] cmd, input logic [31:0] ra,
                               input logic [31:0] rb, input logic last);
    longint a, b, s, c, x, y;
    a = longint'(signed'(ra));
    b = longint'(signed'(rb));
    case (cmd)
      CMD_LOAD: begin
        if (load_pos < NVERT) begin
          orig_x[load_pos] = a;
          orig_y[load_pos] = b;
          load_pos++;
        end
        if (last) begin
          orig_cnt = load_pos;
          load_pos = 0;
        end
      end
      CMD_COPY: begin
        emit_working();
        for (int k = 0; k < orig_cnt; k++) begin
          work_x[k] = orig_x[k];
          work_y[k] = orig_y[k];
        end
        work_cnt = orig_cnt;
        work_valid = 1;
      end
      CMD_SCALE:
        for (int k = 0; k < work_cnt; k++) begin
          work_x[k] = fix_mul(work_x[k], a, 16);
          work_y[k] = fix_mul(work_y[k], b, 16);
        end
      CMD_TRANSLATE:
        for (int k = 0; k < work_cnt; k++) begin
          work_x[k] = clamp32(work_x[k] + a);
          work_y[k] = clamp32(work_y[k] + b);
        end
      CMD_ROTATE: begin
        angle_sincos(a, s, c);
        for (int k = 0; k < work_cnt; k++) begin
          x = work_x[k];
          y = work_y[k];
          work_x[k] = clamp32(fix_mul(x, c, 30) - fix_mul(y, s, 30));
          work_y[k] = clamp32(fix_mul(x, s, 30) + fix_mul(y, c, 30));
        end
      end
      CMD_FLUSH: begin
        emit_working();
        work_valid = 0;
        work_cnt = 0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got %h, expected %h (point %0d)", what, got, want, points_seen);
  endtask

  // Most gaps are short, a few are long, and some stretches have none.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) quiet_stretch = !quiet_stretch;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: presents queued words, holding each until it is taken. A word
  // marked drain_first also waits out the cycle in which the previous word
  // is taken, so the points that word emits are already expected.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (cmd_queue.size() > 0 &&
                   !(cmd_queue[0].drain_first &&
                     (point_queue.size() > 0 || (in_ch.valid && in_ch.ready)))) begin
        in_ch.command     <= cmd_queue[0].command;
        in_ch.value_a     <= cmd_queue[0].value_a;
        in_ch.value_b     <= cmd_queue[0].value_b;
        in_ch.last_vertex <= cmd_queue[0].last_vertex;
        in_ch.valid       <= 1'b1;
        void'(cmd_queue.pop_front());
        send_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls with the same gap profile as the sender.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready) stall_left <= pick_gap();
    end
  end

  // Monitors: the predictor runs on each accepted command word, and each
  // accepted output word is checked against the oldest expected vertex.
  always @(posedge clk) begin
    point_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        words_sent++;
        apply_command(in_ch.command, in_ch.value_a, in_ch.value_b, in_ch.last_vertex);
      end
      if (out_ch.valid && out_ch.ready) begin
        points_seen++;
        if (point_queue.size() == 0) begin
          report_mismatch("unexpected point_x", out_ch.point_x, 'x);
        end else begin
          want = point_queue.pop_front();
          if (out_ch.point_x !== want.x) report_mismatch("point_x", out_ch.point_x, want.x);
          if (out_ch.point_y !== want.y) report_mismatch("point_y", out_ch.point_y, want.y);
          if (out_ch.last_point !== want.last)
            report_mismatch("last_point", {31'd0, out_ch.last_point}, {31'd0, want.last});
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Watchdog expired with %0d words queued, %0d points expected",
               cmd_queue.size(), point_queue.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(input logic [2:0] cmd, input logic [31:0] a,
                           input logic [31:0] b, input logic last, input bit drain);
    cmd_word_t w;
    w.command = cmd; w.value_a = a; w.value_b = b;
    w.last_vertex = last; w.drain_first = drain;
    cmd_queue.push_back(w);
  endtask

  function automatic logic [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 32'h00C80000) - 32'h00640000;  // about +-100
    if (r < 8) return $urandom();
    return (r == 8) ? 32'h7FFFFFFF : 32'h80000000;
  endfunction

  function automatic logic [31:0] pick_factor();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $urandom_range(0, 32'h00060000) - 32'h00030000;  // about +-3.0
  endfunction

  function automatic logic [31:0] pick_angle();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $urandom_range(0, 32'h05A00000) - 32'h02D00000;  // about +-720 degrees
  endfunction

  task automatic push_polygon(input int n, input bit with_last);
    for (int i = 0; i < n; i++)
      push_word(CMD_LOAD, pick_coord(), pick_coord(), with_last && (i == n - 1), 0);
  endtask

  int count_target;
  int nv;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.value_a = '0;
    in_ch.value_b = '0;
    in_ch.last_vertex = 1'b0;
    out_ch.ready = 1'b0;

    // Directed part. A copy right after reset gives an empty but valid
    // polygon, so the flush that follows emits nothing.
    push_word(CMD_COPY, 32'h0, 32'h0, 0, 0);
    push_word(CMD_FLUSH, 32'h0, 32'h0, 0, 0);
    push_word(CMD_LOAD, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    push_word(CMD_LOAD, 32'h80000000, 32'h7FFFFFFF, 0, 0);
    push_word(CMD_LOAD, 32'h00010000, 32'hFFFF0000, 1, 0);
    push_word(CMD_COPY, 32'h0, 32'h0, 0, 0);       // nothing valid yet
    push_word(CMD_FLUSH, 32'h0, 32'h0, 0, 0);      // emits the triangle
    push_word(CMD_FLUSH, 32'h0, 32'h0, 0, 0);      // already ended
    push_word(CMD_SCALE, 32'h00020000, 32'h00020000, 0, 0);  // no valid polygon
    push_word(CMD_COPY, 32'h0, 32'h0, 0, 0);
    push_word(CMD_SCALE, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    push_word(CMD_TRANSLATE, 32'h80000000, 32'h7FFFFFFF, 0, 0);
    push_word(CMD_COPY, 32'h0, 32'h0, 0, 0);
    push_word(CMD_ROTATE, 32'h005A0000, 32'h0, 0, 0);    // 90
    push_word(CMD_ROTATE, 32'hFFA60000, 32'h0, 0, 0);    // -90
    push_word(CMD_ROTATE, 32'h00B40000, 32'h0, 0, 0);    // 180
    push_word(CMD_ROTATE, 32'h0195_0000, 32'h0, 0, 0);   // 405
    push_word(CMD_ROTATE, 32'hFD300000, 32'h0, 0, 0);    // -720
    push_word(CMD_ROTATE, 32'h80000000, 32'h0, 0, 0);
    push_word(CMD_SPARE6, $urandom(), $urandom(), 1, 0);
    push_word(CMD_SPARE7, $urandom(), $urandom(), 1, 0);
    push_word(CMD_TRANSLATE, 32'hFFFFFFFF, 32'h00000001, 0, 0);
    push_word(CMD_FLUSH, 32'h0, 32'h0, 0, 1);

    // Random part: mostly well-formed load / copy / transform / emit runs.
    count_target = cmd_queue.size() + 460;
    while (cmd_queue.size() < count_target) begin
      case ($urandom_range(0, 19))
        0: push_word($urandom_range(0, 7), $urandom(), $urandom(), $urandom_range(0, 1), 0);
        1: push_polygon($urandom_range(1, 4), 0);     // load left open
        default: begin
          nv = $urandom_range(0, 19);
          nv = (nv < 15) ? $urandom_range(1, 8) : (nv < 19) ? $urandom_range(9, 64)
                                                            : $urandom_range(65, 70);
          push_polygon(nv, 1);
          push_word(CMD_COPY, $urandom(), $urandom(), $urandom_range(0, 1), 0);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 2))
              0: push_word(CMD_SCALE, pick_factor(), pick_factor(), 0, 0);
              1: push_word(CMD_TRANSLATE, pick_coord(), pick_coord(), 0, 0);
              default: push_word(CMD_ROTATE, pick_angle(), $urandom(), 0, 0);
            endcase
          end
          push_word($urandom_range(0, 1) ? CMD_FLUSH : CMD_COPY, $urandom(), $urandom(),
                    $urandom_range(0, 1), $urandom_range(0, 15) == 0);
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (cmd_queue.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (point_queue.size() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d command words and checked %0d emitted vertices,", words_sent,
             points_seen);
    $display("covering loads with overflow, copies, flushes, all transforms and spare codes.");
    if (error_count == 0 && point_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d points never seen", error_count, point_queue.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pat_pkg.sv
rtl/core/pat_ifs.sv
rtl/core/pat_sincos.sv
rtl/core/polygon_affine_transform_top.sv
bench/tb_polygon_affine_transform_top.sv
